// ===== design/random_permutation_generator_core_defines.svh =====
// assertion macros used by the rtl file rpg_ctrl.sv
`ifndef RANDOM_PERMUTATION_GENERATOR_CORE_DEFINES_SVH
`define RANDOM_PERMUTATION_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define RPG_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rpg check failed");

// next-cycle implication
`define RPG_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rpg check failed");

`endif

// ===== design/rpg_pkg.sv =====
package rpg_pkg;

  localparam logic [47:0] GEN_MUL    = 48'h0005_DEEC_E66D;
  localparam logic [47:0] GEN_ADD    = 48'h0000_0000_000B;
  localparam logic [47:0] SEED_RESET = 48'h1234_ABCD_330E;

  typedef struct packed {
    logic [47:0] a;
    logic [15:0] b;
  } mul_req_t;

  typedef enum logic [10:0] {
    ST_IDLE       = 11'b000_0000_0001,
    ST_FILL       = 11'b000_0000_0010,
    ST_GEN0       = 11'b000_0000_0100,
    ST_GEN1       = 11'b000_0000_1000,
    ST_GEN2       = 11'b000_0001_0000,
    ST_GEN3       = 11'b000_0010_0000,
    ST_SLOT       = 11'b000_0100_0000,
    ST_PICK       = 11'b000_1000_0000,
    ST_EMIT       = 11'b001_0000_0000,
    ST_FINAL_RD   = 11'b010_0000_0000,
    ST_FINAL_EMIT = 11'b100_0000_0000
  } state_t;

endpackage

// ===== design/rpg_if.sv =====
interface rpg_req_if;
  logic       valid;
  logic       ready;
  logic [6:0] length;
  modport source (output valid, output length, input ready);
  modport sink (input valid, input length, output ready);
endinterface

interface rpg_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] value;
  logic [5:0] position;
  logic       last;
  modport source (output valid, output value, output position, output last, input ready);
  modport sink (input valid, input value, input position, input last, output ready);
endinterface

interface rpg_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] seed;
  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

// ===== design/random_permutation_generator_core.sv =====
// random permutation generator
// req carries a length n (1..MAX_LENGTH, larger values saturate, zero gives
// nothing); the block answers with n results on rsp, a shuffled 0..n-1,
// each with its position and last set on the final one.
// the user must write the 48-bit generator seed on cfg only while the block
// is idle; the block itself does not enforce this. per request: the pick
// buffer is loaded (FILL), then each of the n-1 picks steps through GEN0,
// GEN1, GEN2, GEN3, SLOT, PICK and EMIT, then FINAL_RD and FINAL_EMIT give
// the final element; the next request is taken once idle. each pick uses
// the shared 48x16 multiplier four times: three partial products of the
// generator step and one for the scaled slot; that multiplier sets the pace.
// req is ready only while no request is in progress; the output register
// lets a new request enter while the last result still waits.
// a stall on rsp holds the sequencer at the element that is waiting.
// reset (rst, synchronous) loads the seed 0x1234ABCD330E, clears the
// output valid and returns to idle; the pick buffer needs no clearing.
module random_permutation_generator_core
  import rpg_pkg::*;
#(
  parameter int MAX_LENGTH = 64
) (
  input logic       clk,
  input logic       rst,
  rpg_req_if.sink   req,
  rpg_rsp_if.source rsp,
  rpg_cfg_if.sink   cfg
);

  localparam int IW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);

  mul_req_t      mreq;
  logic [63:0]   prod;
  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] wdata;
  logic          re;
  logic [IW-1:0] raddr_a;
  logic [IW-1:0] raddr_b;
  logic [IW-1:0] rdata_a;
  logic [IW-1:0] rdata_b;

  rpg_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  rpg_pick_buf #(
    .DEPTH (MAX_LENGTH),
    .AW    (IW)
  ) u_pick_buf (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  rpg_ctrl #(
    .MAX_LENGTH (MAX_LENGTH),
    .IW         (IW),
    .CW         (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cfg     (cfg),
    .mreq    (mreq),
    .prod    (prod),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

endmodule

// ===== design/rpg_mul.sv =====
module rpg_mul
  import rpg_pkg::*;
(
  input  logic        clk,
  input  mul_req_t    req,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= {16'b0, req.a} * {48'b0, req.b};
  end

endmodule

// ===== design/rpg_pick_buf.sv =====
module rpg_pick_buf #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [AW-1:0] rdata_a,
  output logic [AW-1:0] rdata_b
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/rpg_ctrl.sv =====
`include "random_permutation_generator_core_defines.svh"

module rpg_ctrl
  import rpg_pkg::*;
#(
  parameter int MAX_LENGTH = 64,
  parameter int IW         = 6,
  parameter int CW         = 7
) (
  input  logic          clk,
  input  logic          rst,
  rpg_req_if.sink       req,
  rpg_rsp_if.source     rsp,
  rpg_cfg_if.sink       cfg,
  output mul_req_t      mreq,
  input  logic [63:0]   prod,
  output logic          we,
  output logic [IW-1:0] waddr,
  output logic [IW-1:0] wdata,
  output logic          re,
  output logic [IW-1:0] raddr_a,
  output logic [IW-1:0] raddr_b,
  input  logic [IW-1:0] rdata_a,
  input  logic [IW-1:0] rdata_b
);

  state_t        state;
  state_t        state_next;
  logic [47:0]   x;
  logic [47:0]   acc;
  logic [CW-1:0] n;
  logic [CW-1:0] n_sat;
  logic [CW-1:0] k;
  logic [CW-1:0] i;
  logic [CW-1:0] live;
  logic [IW-1:0] slot;
  logic          o_valid;
  logic [5:0]    o_value;
  logic [5:0]    o_position;
  logic          o_last;
  logic          out_free;
  logic          req_fire;

  assign out_free = !o_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);
  assign req_fire = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid    = o_valid;
  assign rsp.value    = o_value;
  assign rsp.position = o_position;
  assign rsp.last     = o_last;

  assign n_sat = (req.length > 7'(MAX_LENGTH)) ? CW'(MAX_LENGTH) : CW'(req.length);

  always_comb begin
    mreq.a = GEN_MUL;
    mreq.b = 16'b0;
    unique case (state)
      ST_GEN0: mreq.b = x[15:0];
      ST_GEN1: mreq.b = x[31:16];
      ST_GEN2: mreq.b = x[47:32];
      ST_SLOT: begin
        mreq.a = x;
        mreq.b = 16'(live);
      end
      default: mreq.b = 16'b0;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    waddr   = slot;
    wdata   = rdata_b;
    re      = 1'b0;
    raddr_a = prod[48 +: IW];
    raddr_b = IW'(live - CW'(1));
    unique case (state)
      ST_FILL: begin
        we    = 1'b1;
        waddr = k[IW-1:0];
        wdata = k[IW-1:0];
      end
      ST_PICK: re = 1'b1;
      ST_EMIT: we = out_free;
      ST_FINAL_RD: begin
        re      = 1'b1;
        raddr_a = '0;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && n_sat != '0) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (k == n - CW'(1)) begin
          state_next = (n == CW'(1)) ? ST_FINAL_RD : ST_GEN0;
        end
      end
      ST_GEN0: state_next = ST_GEN1;
      ST_GEN1: state_next = ST_GEN2;
      ST_GEN2: state_next = ST_GEN3;
      ST_GEN3: state_next = ST_SLOT;
      ST_SLOT: state_next = ST_PICK;
      ST_PICK: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = (live == CW'(2)) ? ST_FINAL_RD : ST_GEN0;
        end
      end
      ST_FINAL_RD: state_next = ST_FINAL_EMIT;
      ST_FINAL_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
      x       <= SEED_RESET;
    end else begin
      state <= state_next;
      if ((state == ST_EMIT || state == ST_FINAL_EMIT) && out_free) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      if (state == ST_GEN3) begin
        x <= acc + {prod[15:0], 32'b0} + GEN_ADD;
      end else if (cfg.valid && cfg.ready) begin
        x <= cfg.seed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      n    <= n_sat;
      k    <= '0;
      i    <= '0;
      live <= n_sat;
    end
    if (state == ST_FILL) begin
      k <= k + CW'(1);
    end
    if (state == ST_GEN1) begin
      acc <= prod[47:0];
    end
    if (state == ST_GEN2) begin
      acc <= acc + {prod[31:0], 16'b0};
    end
    if (state == ST_PICK) begin
      slot <= prod[48 +: IW];
    end
    if (state == ST_EMIT && out_free) begin
      o_value    <= 6'(rdata_a);
      o_position <= 6'(i);
      o_last     <= 1'b0;
      i          <= i + CW'(1);
      live       <= live - CW'(1);
    end
    if (state == ST_FINAL_EMIT && out_free) begin
      o_value    <= 6'(rdata_a);
      o_position <= 6'(n - CW'(1));
      o_last     <= 1'b1;
    end
  end

  `RPG_ASSERT_NOW(a_slot_in_range, state == ST_EMIT, CW'(slot) < live)
  `RPG_ASSERT_NOW(a_step_count, state == ST_EMIT, (i + live) == n)
  `RPG_ASSERT_NOW(a_gen_needs_two, state == ST_GEN0, n > CW'(1))
  `RPG_ASSERT_NEXT(a_final_is_last, state == ST_FINAL_EMIT && out_free, o_valid && o_last)

endmodule
